// ===== design/hbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_pkg: shared types and constants of the heartbeat monitor
// Item formats, operation codes, sequencer states, the internal control
// structs, and the default settings table for every channel.
// ----------------------------------------------------------------------------
package hbm_pkg;

    localparam int NUM_CHANNELS_DEF = 14;
    localparam int TIME_WIDTH_DEF   = 32;
    localparam int DFLT_ROWS        = 14;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BEAT  = 2'd1,
        OP_SCAN  = 2'd2,
        OP_WRITE = 2'd3
    } hbm_op_t;

    typedef struct packed {
        hbm_op_t     op;
        logic [3:0]  channel;
        logic        data_bad;
        logic [15:0] offline_limit;
        logic [15:0] online_limit;
        logic [3:0]  prio_level;
        logic        chan_enable;
    } hbm_req_t;

    typedef struct packed {
        logic        channel_error;
        logic        channel_lost;
        logic [3:0]  top_lost_channel;
        logic        any_lost;
        logic        any_error;
        logic [13:0] lost_mask;
        logic        data_fault_action;
    } hbm_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_OFF,
        ST_SCAN_ON,
        ST_REPORT
    } hbm_state_t;

    // Comparison performed by the shared elapsed-time unit.
    typedef enum logic {
        CMP_OVER,
        CMP_UNDER
    } hbm_cmp_mode_t;

    // Update commands from the sequencer to the channel table.
    typedef struct packed {
        logic beat;
        logic cfg_wr;
        logic off_hit;
        logic on_chk;
        logic on_hit;
    } hbm_tbl_cmd_t;

    // Per-channel status bits as read from the table.
    typedef struct packed {
        logic enabled;
        logic err;
        logic lost;
        logic bad;
    } hbm_flags_t;

    // Sequencer controls toward the top level.
    typedef struct packed {
        logic tick;
        logic out_load;
        logic chan_valid;
        logic fault;
    } hbm_seq_ctl_t;

    localparam logic [15:0] DFLT_OFFLINE [DFLT_ROWS] = '{
        16'd30, 16'd10, 16'd10, 16'd10, 16'd10, 16'd2, 16'd2,
        16'd10, 16'd2, 16'd5, 16'd40, 16'd100, 16'd10, 16'd100
    };

    localparam logic [15:0] DFLT_ONLINE [DFLT_ROWS] = '{
        16'd40, 16'd10, 16'd10, 16'd10, 16'd10, 16'd3, 16'd3,
        16'd10, 16'd3, 16'd5, 16'd200, 16'd100, 16'd10, 16'd100
    };

    localparam logic [3:0] DFLT_PRIO [DFLT_ROWS] = '{
        4'd15, 4'd11, 4'd10, 4'd9, 4'd8, 4'd14, 4'd13,
        4'd12, 4'd7, 4'd7, 4'd7, 4'd5, 4'd7, 4'd1
    };

    // Channels past the end of the table take its last row.
    function automatic int unsigned dflt_row(int unsigned ch);
        return (ch < DFLT_ROWS) ? ch : DFLT_ROWS - 1;
    endfunction

    function automatic logic [15:0] dflt_offline(int unsigned ch);
        return DFLT_OFFLINE[dflt_row(ch)];
    endfunction

    function automatic logic [15:0] dflt_online(int unsigned ch);
        return DFLT_ONLINE[dflt_row(ch)];
    endfunction

    function automatic logic [3:0] dflt_prio(int unsigned ch);
        return DFLT_PRIO[dflt_row(ch)];
    endfunction

endpackage
`default_nettype wire

// ===== design/hbm_elapsed_cmp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_elapsed_cmp: shared elapsed-time compare unit
// Subtracts a stored time stamp from the current time, modulo the counter
// width, and compares the result against a 16-bit limit.
// ----------------------------------------------------------------------------
module hbm_elapsed_cmp #(
    parameter int TIME_WIDTH = hbm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic [TIME_WIDTH-1:0] now,
    input  wire logic [TIME_WIDTH-1:0] since,
    input  wire logic [15:0]           limit,
    input  wire hbm_pkg::hbm_cmp_mode_t mode,
    output logic                       hit
);

    logic [TIME_WIDTH-1:0] elapsed;
    logic [TIME_WIDTH-1:0] limit_ext;

    assign elapsed   = now - since;
    assign limit_ext = TIME_WIDTH'(limit);

    always_comb
    begin
        case (mode)
            hbm_pkg::CMP_OVER:  hit = (elapsed > limit_ext);
            hbm_pkg::CMP_UNDER: hit = (elapsed < limit_ext);
            default:            hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ===== design/hbm_chan_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_chan_table: per-channel settings and status table
// Holds time stamps, limits, priority and status flags of every channel.
// One address is read and updated per cycle under sequencer commands.
// ----------------------------------------------------------------------------
module hbm_chan_table #(
    parameter int NUM_CHANNELS = hbm_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_WIDTH   = hbm_pkg::TIME_WIDTH_DEF,
    parameter int CH_W         = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [CH_W-1:0]       addr,
    input  wire logic [TIME_WIDTH-1:0] now,
    input  wire hbm_pkg::hbm_tbl_cmd_t cmd,
    input  wire hbm_pkg::hbm_req_t     item,
    output logic [TIME_WIDTH-1:0]      last_beat,
    output logic [TIME_WIDTH-1:0]      settle_start,
    output logic [15:0]                offline_limit,
    output logic [15:0]                online_limit,
    output logic [3:0]                 prio,
    output hbm_pkg::hbm_flags_t        flags
);

    logic [TIME_WIDTH-1:0] last_beat_reg [NUM_CHANNELS];
    logic [TIME_WIDTH-1:0] settle_reg    [NUM_CHANNELS];
    logic [15:0]           offline_reg   [NUM_CHANNELS];
    logic [15:0]           online_reg    [NUM_CHANNELS];
    logic [3:0]            prio_reg      [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] enabled_reg;
    logic [NUM_CHANNELS-1:0] err_reg;
    logic [NUM_CHANNELS-1:0] lost_reg;
    logic [NUM_CHANNELS-1:0] bad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                last_beat_reg[i] <= '0;
                settle_reg[i]    <= '0;
                offline_reg[i]   <= hbm_pkg::dflt_offline(i);
                online_reg[i]    <= hbm_pkg::dflt_online(i);
                prio_reg[i]      <= hbm_pkg::dflt_prio(i);
            end
            enabled_reg <= '1;
            err_reg     <= '1;
            lost_reg    <= '1;
            bad_reg     <= '1;
        end
        else
        begin
            if (cmd.beat)
            begin
                last_beat_reg[addr] <= now;
                // A lost channel that speaks again starts its settling window.
                if (lost_reg[addr])
                begin
                    lost_reg[addr]   <= 1'b0;
                    settle_reg[addr] <= now;
                end
                if (item.data_bad)
                begin
                    err_reg[addr] <= 1'b1;
                    bad_reg[addr] <= 1'b1;
                end
                else
                begin
                    bad_reg[addr] <= 1'b0;
                end
            end
            if (cmd.cfg_wr)
            begin
                offline_reg[addr] <= item.offline_limit;
                online_reg[addr]  <= item.online_limit;
                prio_reg[addr]    <= item.prio_level;
                enabled_reg[addr] <= item.chan_enable;
            end
            // An offline channel already in error keeps its lost flag as is.
            if (cmd.off_hit && !err_reg[addr])
            begin
                lost_reg[addr] <= 1'b1;
                err_reg[addr]  <= 1'b1;
            end
            if (cmd.on_chk)
            begin
                lost_reg[addr] <= 1'b0;
                err_reg[addr]  <= cmd.on_hit | bad_reg[addr];
            end
        end
    end

    assign last_beat     = last_beat_reg[addr];
    assign settle_start  = settle_reg[addr];
    assign offline_limit = offline_reg[addr];
    assign online_limit  = online_reg[addr];
    assign prio          = prio_reg[addr];
    assign flags.enabled = enabled_reg[addr];
    assign flags.err     = err_reg[addr];
    assign flags.lost    = lost_reg[addr];
    assign flags.bad     = bad_reg[addr];

endmodule
`default_nettype wire

// ===== design/hbm_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hbm_seq: operation sequencer of the heartbeat monitor
// Takes one item at a time, issues table updates, walks the channels during
// a scan with the shared compare unit, and keeps the scan summary.
// ----------------------------------------------------------------------------
module hbm_seq #(
    parameter int NUM_CHANNELS = hbm_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_WIDTH   = hbm_pkg::TIME_WIDTH_DEF,
    parameter int CH_W         = 4,
    parameter int TOP_W        = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire hbm_pkg::hbm_req_t      req,
    input  wire logic                   out_free,
    input  wire hbm_pkg::hbm_flags_t    flags,
    input  wire logic [3:0]             prio,
    input  wire logic [TIME_WIDTH-1:0]  last_beat,
    input  wire logic [TIME_WIDTH-1:0]  settle_start,
    input  wire logic [15:0]            offline_limit,
    input  wire logic [15:0]            online_limit,
    input  wire logic                   cmp_hit,
    output logic [TIME_WIDTH-1:0]       cmp_since,
    output logic [15:0]                 cmp_limit,
    output hbm_pkg::hbm_cmp_mode_t      cmp_mode,
    output logic [CH_W-1:0]             tbl_addr,
    output hbm_pkg::hbm_tbl_cmd_t       tbl_cmd,
    output hbm_pkg::hbm_req_t           item,
    output hbm_pkg::hbm_seq_ctl_t       ctl,
    output logic [TOP_W-1:0]            sum_top,
    output logic                        sum_any,
    output logic [NUM_CHANNELS-1:0]     sum_mask
);

    localparam logic [TOP_W-1:0] NONE_CODE = TOP_W'(NUM_CHANNELS);
    localparam logic [CH_W-1:0]  LAST_IDX  = CH_W'(NUM_CHANNELS - 1);

    hbm_pkg::hbm_state_t     state_reg, state_next;
    hbm_pkg::hbm_req_t       item_reg;
    logic [CH_W-1:0]         idx_reg;
    logic [3:0]              best_reg;
    logic [TOP_W-1:0]        sum_top_reg;
    logic                    sum_any_reg;
    logic [NUM_CHANNELS-1:0] sum_mask_reg;

    logic            accept;
    logic            chan_valid;
    logic [CH_W-1:0] chan_addr;
    logic            last_idx;
    logic            off_found;
    logic            advance;

    assign accept     = req_valid & req_ready;
    assign chan_valid = (32'(item_reg.channel) < 32'(NUM_CHANNELS));
    assign chan_addr  = chan_valid ? CH_W'(item_reg.channel) : '0;
    assign last_idx   = (idx_reg == LAST_IDX);
    assign off_found  = (state_reg == hbm_pkg::ST_SCAN_OFF) & flags.enabled & cmp_hit;
    // A channel is done after its offline check when it is skipped or offline.
    assign advance    = ((state_reg == hbm_pkg::ST_SCAN_OFF) & (!flags.enabled | cmp_hit))
                      | (state_reg == hbm_pkg::ST_SCAN_ON);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbm_pkg::ST_IDLE:
            begin
                if (req_valid)
                    state_next = hbm_pkg::ST_EXEC;
            end
            hbm_pkg::ST_EXEC:
            begin
                if (item_reg.op == hbm_pkg::OP_SCAN)
                    state_next = hbm_pkg::ST_SCAN_OFF;
                else
                    state_next = hbm_pkg::ST_REPORT;
            end
            hbm_pkg::ST_SCAN_OFF:
            begin
                if (flags.enabled && !cmp_hit)
                    state_next = hbm_pkg::ST_SCAN_ON;
                else if (last_idx)
                    state_next = hbm_pkg::ST_REPORT;
            end
            hbm_pkg::ST_SCAN_ON:
            begin
                if (last_idx)
                    state_next = hbm_pkg::ST_REPORT;
                else
                    state_next = hbm_pkg::ST_SCAN_OFF;
            end
            hbm_pkg::ST_REPORT:
            begin
                if (out_free)
                    state_next = hbm_pkg::ST_IDLE;
            end
            default: state_next = hbm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        tbl_cmd        = '0;
        tbl_addr       = chan_addr;
        cmp_mode       = hbm_pkg::CMP_OVER;
        cmp_since      = last_beat;
        cmp_limit      = offline_limit;
        ctl.tick       = 1'b0;
        ctl.out_load   = 1'b0;
        ctl.chan_valid = chan_valid;
        ctl.fault      = (item_reg.op == hbm_pkg::OP_BEAT) & chan_valid & item_reg.data_bad;
        case (state_reg)
            hbm_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            hbm_pkg::ST_EXEC:
            begin
                case (item_reg.op)
                    hbm_pkg::OP_TICK:  ctl.tick       = 1'b1;
                    hbm_pkg::OP_BEAT:  tbl_cmd.beat   = chan_valid;
                    hbm_pkg::OP_WRITE: tbl_cmd.cfg_wr = chan_valid;
                    default:           tbl_cmd        = '0;
                endcase
            end
            hbm_pkg::ST_SCAN_OFF:
            begin
                tbl_addr        = idx_reg;
                tbl_cmd.off_hit = off_found;
            end
            hbm_pkg::ST_SCAN_ON:
            begin
                tbl_addr       = idx_reg;
                cmp_mode       = hbm_pkg::CMP_UNDER;
                cmp_since      = settle_start;
                cmp_limit      = online_limit;
                tbl_cmd.on_chk = 1'b1;
                tbl_cmd.on_hit = cmp_hit;
            end
            hbm_pkg::ST_REPORT:
            begin
                ctl.out_load = out_free;
            end
            default: req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= hbm_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            best_reg     <= '0;
            sum_top_reg  <= NONE_CODE;
            sum_any_reg  <= 1'b0;
            sum_mask_reg <= '0;
        end
        else if (state_reg == hbm_pkg::ST_EXEC && item_reg.op == hbm_pkg::OP_SCAN)
        begin
            // The summary is rebuilt in place; every result loaded after the walk reports it.
            idx_reg      <= '0;
            best_reg     <= '0;
            sum_top_reg  <= NONE_CODE;
            sum_any_reg  <= 1'b0;
            sum_mask_reg <= '0;
        end
        else
        begin
            if (off_found)
            begin
                if (prio > best_reg)
                begin
                    best_reg    <= prio;
                    sum_top_reg <= TOP_W'(idx_reg);
                end
                sum_any_reg  <= 1'b1;
                sum_mask_reg <= sum_mask_reg | (NUM_CHANNELS'(1) << idx_reg);
            end
            if (advance)
                idx_reg <= idx_reg + CH_W'(1);
        end
    end

    assign item     = item_reg;
    assign sum_top  = sum_top_reg;
    assign sum_any  = sum_any_reg;
    assign sum_mask = sum_mask_reg;

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hbm_pkg::ST_SCAN_OFF || state_reg == hbm_pkg::ST_SCAN_ON)
        |-> (32'(idx_reg) < 32'(NUM_CHANNELS)))
        else $error("scan index beyond the last channel");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == hbm_pkg::ST_EXEC))
        else $error("accepted item did not start execution");

    a_any_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hbm_pkg::ST_IDLE) |-> (sum_any_reg == (sum_mask_reg != '0)))
        else $error("scan summary flag disagrees with mask");

    a_top_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hbm_pkg::ST_IDLE && sum_top_reg != NONE_CODE)
        |-> ((sum_mask_reg & (NUM_CHANNELS'(1) << sum_top_reg)) != '0))
        else $error("top lost channel is not in the lost mask");

    a_report_once: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> (state_reg == hbm_pkg::ST_IDLE))
        else $error("result loaded without returning to idle");
`endif

endmodule
`default_nettype wire

// ===== design/multi_channel_heartbeat_monitor.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_monitor: heartbeat watchdog over many channels
// Keeps a time counter and a channel table; handles ticks, heartbeats,
// settings writes and scans, and returns one result per item.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  req     | in        | req_valid/req_ready  | hbm_req_t (op, channel, limits)
//  rsp     | out       | rsp_valid/rsp_ready  | hbm_rsp_t (flags, scan summary)
//
// Tick, heartbeat and settings items pass from the execute state to the
// report state before their result loads; a scan walks the channels in
// between: the one elapsed-time compare unit checks each enabled channel's
// offline limit, then, if it is not offline, its settling window.
// Reset is asynchronous and loads the default settings table at once.
// The next item is taken in the cycle after a result loads, even while it waits
// in the output register; a stalled result holds the sequencer before it
// loads the following one.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_monitor #(
    parameter int NUM_CHANNELS = hbm_pkg::NUM_CHANNELS_DEF,
    parameter int TIME_WIDTH   = hbm_pkg::TIME_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire hbm_pkg::hbm_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output hbm_pkg::hbm_rsp_t      rsp
);

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TOP_W = $clog2(NUM_CHANNELS + 1);

    logic [TIME_WIDTH-1:0]   now_reg;
    logic                    rsp_valid_reg;
    hbm_pkg::hbm_rsp_t       rsp_reg;

    logic                    out_free;
    hbm_pkg::hbm_flags_t     flags;
    logic [3:0]              prio;
    logic [TIME_WIDTH-1:0]   last_beat;
    logic [TIME_WIDTH-1:0]   settle_start;
    logic [15:0]             offline_limit;
    logic [15:0]             online_limit;
    logic                    cmp_hit;
    logic [TIME_WIDTH-1:0]   cmp_since;
    logic [15:0]             cmp_limit;
    hbm_pkg::hbm_cmp_mode_t  cmp_mode;
    logic [CH_W-1:0]         tbl_addr;
    hbm_pkg::hbm_tbl_cmd_t   tbl_cmd;
    hbm_pkg::hbm_req_t       item;
    hbm_pkg::hbm_seq_ctl_t   ctl;
    logic [TOP_W-1:0]        sum_top;
    logic                    sum_any;
    logic [NUM_CHANNELS-1:0] sum_mask;

    assign out_free = !rsp_valid_reg || rsp_ready;

    hbm_seq #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_WIDTH   (TIME_WIDTH),
        .CH_W         (CH_W),
        .TOP_W        (TOP_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .req           (req),
        .out_free      (out_free),
        .flags         (flags),
        .prio          (prio),
        .last_beat     (last_beat),
        .settle_start  (settle_start),
        .offline_limit (offline_limit),
        .online_limit  (online_limit),
        .cmp_hit       (cmp_hit),
        .cmp_since     (cmp_since),
        .cmp_limit     (cmp_limit),
        .cmp_mode      (cmp_mode),
        .tbl_addr      (tbl_addr),
        .tbl_cmd       (tbl_cmd),
        .item          (item),
        .ctl           (ctl),
        .sum_top       (sum_top),
        .sum_any       (sum_any),
        .sum_mask      (sum_mask)
    );

    hbm_chan_table #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_WIDTH   (TIME_WIDTH),
        .CH_W         (CH_W)
    ) u_table (
        .clk           (clk),
        .rst_n         (rst_n),
        .addr          (tbl_addr),
        .now           (now_reg),
        .cmd           (tbl_cmd),
        .item          (item),
        .last_beat     (last_beat),
        .settle_start  (settle_start),
        .offline_limit (offline_limit),
        .online_limit  (online_limit),
        .prio          (prio),
        .flags         (flags)
    );

    hbm_elapsed_cmp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_cmp (
        .now   (now_reg),
        .since (cmp_since),
        .limit (cmp_limit),
        .mode  (cmp_mode),
        .hit   (cmp_hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            now_reg <= '0;
        else if (ctl.tick)
            now_reg <= now_reg + TIME_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (ctl.out_load)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            rsp_reg.channel_error     <= ctl.chan_valid & flags.err;
            rsp_reg.channel_lost      <= ctl.chan_valid & flags.lost;
            rsp_reg.top_lost_channel  <= 4'(sum_top);
            rsp_reg.any_lost          <= sum_any;
            rsp_reg.any_error         <= sum_any;
            rsp_reg.lost_mask         <= 14'(sum_mask);
            rsp_reg.data_fault_action <= ctl.fault;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
`default_nettype wire
